/* rtl/sbt_pkg.sv */
// Shared constants, commands, status codes and types of the breakpoint table.
`default_nettype none
package sbt_pkg;

    // Table size and derived widths
    localparam int BREAKPOINT_SLOTS = 32;
    localparam int IDX_W  = (BREAKPOINT_SLOTS > 1) ? $clog2(BREAKPOINT_SLOTS) : 1;
    localparam int CNT_W  = $clog2(BREAKPOINT_SLOTS + 1);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 20;
    localparam int OPC_W  = 8;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 5;

    // Stream data widths, padded to whole bytes
    localparam int IN_W   = 32;
    localparam int OUT_W  = 40;

    // Commands
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISARM = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_SET_OK = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_PATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd4;

    // Breakpoint opcode written on arm
    localparam logic [OPC_W-1:0] TRAP_OPCODE = 8'hCC;

    // One table slot
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [OPC_W-1:0]  opcode;
    } entry_t;

    // Control of the slot ring
    typedef struct packed {
        logic   shift;
        logic   load;
        entry_t load_entry;
    } chain_ctrl_t;

endpackage
`default_nettype wire

/* rtl/sbt_cell.sv */
// One slot cell of the ring: holds an entry and takes its neighbour's on a shift.
`default_nettype none
module sbt_cell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire sbt_pkg::entry_t shift_in,
    output sbt_pkg::entry_t      entry_q
);
    import sbt_pkg::*;

    entry_t entry_reg;

    // Take the neighbour's entry on a shift, otherwise hold
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= shift_in;
        end
    end

    assign entry_q = entry_reg;

endmodule
`default_nettype wire

/* rtl/sbt_chain.sv */
// Ring of slot cells; the head cell presents slot k at scan step k.
`default_nettype none
module sbt_chain (
    input  wire logic                 aclk,
    input  wire sbt_pkg::chain_ctrl_t ctrl,
    output sbt_pkg::entry_t           head
);
    import sbt_pkg::*;

    entry_t cell_q [BREAKPOINT_SLOTS];
    entry_t cell_d [BREAKPOINT_SLOTS];

    genvar i;
    generate
        for (i = 0; i < BREAKPOINT_SLOTS; i++) begin : g_cell
            // Tail takes the head back, or a new entry on a set
            if (i == BREAKPOINT_SLOTS - 1) begin : g_tail
                assign cell_d[i] = ctrl.load ? ctrl.load_entry : cell_q[0];
            end else begin : g_body
                assign cell_d[i] = cell_q[i+1];
            end

            sbt_cell u_cell (
                .aclk     (aclk),
                .shift_en (ctrl.shift),
                .shift_in (cell_d[i]),
                .entry_q  (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];

endmodule
`default_nettype wire

/* rtl/software_breakpoint_table.sv */
// Top level of the breakpoint table: command control, slot ring and result register.
//
//  Channel | Direction | Handshake        | Contents
//  s_      | in        | tvalid / tready  | command, linear_address, original_byte
//  m_      | out       | tvalid / tready  | status, patch_address, patch_byte,
//          |           |                  | slot_index, hit; tlast = last
//
// Every command but the unused code is taken in one transfer and then runs one ring
// rotation per slot, pausing while the result side stalls, so that the ring is back in
// slot order at the end.
// Each cycle that would emit a result waits while the result register is full.
// Reset clears the fill count, so the table comes up empty; slot contents are not reset.
// The next command is taken while the last result still waits in the output register.
`default_nettype none
module software_breakpoint_table (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // [1:0] command, [21:2] linear_address, [29:22] original_byte
    input  wire logic [sbt_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [2:0] status, [22:3] patch_address, [30:23] patch_byte,
    // [35:31] slot_index, [36] hit
    output logic [sbt_pkg::OUT_W-1:0]      m_tdata,
    output logic                           m_tlast
);
    import sbt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] key_reg;
    logic [OPC_W-1:0]  opcode_reg;
    logic [IDX_W-1:0]  step_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              flag_reg;

    logic              m_tvalid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [ADDR_W-1:0] paddr_reg;
    logic [OPC_W-1:0]  pbyte_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              hit_reg;
    logic              last_reg;

    chain_ctrl_t       ring_ctrl;
    entry_t            head;

    logic              accept;
    logic [CNT_W-1:0]  step_ext;
    logic [CNT_W-1:0]  step_plus;
    logic              last_step;
    logic              step_valid;
    logic              step_final;
    logic              table_full;
    logic              flag_now;
    logic              out_free;
    logic              emit;
    logic              adv;
    logic              is_set;
    logic              set_ok;

    logic [STAT_W-1:0] status_d;
    logic [ADDR_W-1:0] paddr_d;
    logic [OPC_W-1:0]  pbyte_d;
    logic [SLOT_W-1:0] slot_d;
    logic              hit_d;
    logic              last_d;

    // Slot ring
    sbt_chain u_chain (
        .aclk (aclk),
        .ctrl (ring_ctrl),
        .head (head)
    );

    // Scan bookkeeping
    assign accept     = s_tvalid && s_tready;
    assign step_ext   = CNT_W'(step_reg);
    assign step_plus  = step_ext + CNT_W'(1);
    assign last_step  = (step_reg == IDX_W'(BREAKPOINT_SLOTS - 1));
    assign step_valid = (step_ext < count_reg);
    assign step_final = (step_plus == count_reg);
    assign table_full = (count_reg == CNT_W'(BREAKPOINT_SLOTS));
    assign flag_now   = flag_reg || (step_valid && (head.address == key_reg));
    assign out_free   = !m_tvalid_reg || m_tready;
    assign is_set     = (cmd_reg == CMD_SET);
    assign set_ok     = !flag_now && !table_full;

    // Decide whether this step emits a result and build it
    always_comb begin
        emit     = 1'b0;
        status_d = ST_PATCH;
        paddr_d  = '0;
        pbyte_d  = '0;
        slot_d   = '0;
        hit_d    = 1'b0;
        last_d   = 1'b0;
        if (is_set) begin
            emit   = last_step;
            last_d = 1'b1;
            if (flag_now) begin
                status_d = ST_DUP;
            end else if (table_full) begin
                status_d = ST_FULL;
            end else begin
                status_d = ST_SET_OK;
                slot_d   = SLOT_W'(count_reg);
            end
        end else if (count_reg == '0) begin
            emit     = (step_reg == '0);
            status_d = ST_EMPTY;
            last_d   = 1'b1;
        end else begin
            emit     = step_valid;
            status_d = ST_PATCH;
            paddr_d  = head.address;
            pbyte_d  = (cmd_reg == CMD_DISARM) ? head.opcode : TRAP_OPCODE;
            slot_d   = SLOT_W'(step_reg);
            last_d   = step_final;
            hit_d    = (cmd_reg == CMD_DISARM) && step_final && flag_now;
        end
    end

    // Rotate one slot per cycle unless a result waits for room
    assign adv = (state_reg == S_SCAN) && (!emit || out_free);

    always_comb begin
        ring_ctrl.shift      = adv;
        ring_ctrl.load       = adv && is_set && (step_ext == count_reg);
        ring_ctrl.load_entry = '{address: key_reg, opcode: opcode_reg};
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_tdata[1:0] == CMD_SET || s_tdata[1:0] == CMD_ARM ||
                               s_tdata[1:0] == CMD_DISARM)) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (adv && last_step) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            step_reg     <= '0;
            flag_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                step_reg <= '0;
                flag_reg <= 1'b0;
            end else if (adv) begin
                step_reg <= last_step ? '0 : IDX_W'(step_reg + IDX_W'(1));
                flag_reg <= flag_now;
            end
            // Grow the table on a successful set
            if (adv && last_step && is_set && set_ok) begin
                count_reg <= step_plus - step_ext + count_reg;
            end
            // Load a result, or drop it once taken
            if (adv && emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_tdata[1:0];
            opcode_reg <= s_tdata[29:22];
            key_reg    <= (s_tdata[1:0] == CMD_DISARM) ?
                          ADDR_W'(s_tdata[21:2] - ADDR_W'(1)) : s_tdata[21:2];
        end
        if (adv && emit) begin
            status_reg <= status_d;
            paddr_reg  <= paddr_d;
            pbyte_reg  <= pbyte_d;
            slot_reg   <= slot_d;
            hit_reg    <= hit_d;
            last_reg   <= last_d;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, hit_reg, slot_reg, pbyte_reg, paddr_reg, status_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

/* rtl/sbt_checker.sv */
// Port-level checks of the breakpoint table, bound to the top level.
`default_nettype none
module sbt_checker (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [sbt_pkg::IN_W-1:0] s_tdata,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [sbt_pkg::OUT_W-1:0] m_tdata,
    input wire logic                     m_tlast
);
    import sbt_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A command that scans closes the input side next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == CMD_SET || s_tdata[1:0] == CMD_ARM ||
                                 s_tdata[1:0] == CMD_DISARM) |=> !s_tready)
        else $error("input taken during a scan");

    // Only patch results come in runs
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_PATCH |-> m_tlast)
        else $error("non-patch result without last");

    // Hit only on the last patch transfer
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[36] |-> m_tlast && m_tdata[2:0] == ST_PATCH)
        else $error("hit outside the last patch");

    // Set and empty results carry no patch
    a_nopatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ST_PATCH |-> m_tdata[30:3] == '0)
        else $error("patch data on a non-patch result");

endmodule

bind software_breakpoint_table sbt_checker u_sbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
